// File: src/nptv6_pkg.sv
`timescale 1ns / 1ps

package nptv6_pkg;

  localparam int WordBits   = 16;
  localparam int NumWords   = 8;
  localparam int PrefixBits = WordBits * NumWords;
  localparam int SumBits    = WordBits + $clog2(NumWords);

  typedef logic [7:0]            len_t;
  typedef logic [63:0]           half_t;
  typedef logic [WordBits-1:0]   word_t;
  typedef logic [PrefixBits-1:0] prefix_t;
  typedef logic [SumBits-1:0]    sum_t;

  localparam word_t WORD_MASK       = 16'hffff;
  localparam len_t  MAX_PREFIX_BITS = 8'd128;

  // two end-around carry folds bring any sum of eight words back to 16 bits
  function automatic word_t fold16(input sum_t v);
    logic [WordBits:0] f1;
    logic [WordBits:0] f2;
    f1 = {1'b0, v[WordBits-1:0]} + {{(2*WordBits+1-SumBits){1'b0}}, v[SumBits-1:WordBits]};
    f2 = {1'b0, f1[WordBits-1:0]} + {{WordBits{1'b0}}, f1[WordBits]};
    return f2[WordBits-1:0];
  endfunction

endpackage

// File: src/nptv6_if.sv
`timescale 1ns / 1ps

// prefix pair channel
interface nptv6_in_if;
  import nptv6_pkg::*;

  logic  valid;
  logic  ready;
  len_t  prefix_length;
  half_t inner_prefix_hi;
  half_t inner_prefix_lo;
  half_t outer_prefix_hi;
  half_t outer_prefix_lo;

  modport source (
    output valid, prefix_length, inner_prefix_hi, inner_prefix_lo,
    output outer_prefix_hi, outer_prefix_lo,
    input  ready
  );
  modport sink (
    input  valid, prefix_length, inner_prefix_hi, inner_prefix_lo,
    input  outer_prefix_hi, outer_prefix_lo,
    output ready
  );
endinterface

// adjustment channel
interface nptv6_out_if;
  import nptv6_pkg::*;

  logic  valid;
  logic  ready;
  word_t adjustment;

  modport source (output valid, adjustment, input ready);
  modport sink (input valid, adjustment, output ready);
endinterface

// File: src/nptv6_prefix_adjustment.sv
`timescale 1ns / 1ps

// NPTv6 checksum-neutral prefix adjustment.
// The prefixes channel carries a prefix length and an inner and an outer
// 128-bit prefix, each split into hi and lo halves in network order. The
// result channel returns one 16-bit ones' complement adjustment per item,
// inner prefix sum minus outer prefix sum.
// Both channels use valid/ready; an item moves when both are high.
// An accepted item passes two register stages: the input register, then
// the result register.
// Throughput: one item per cycle unless stalled; the masked word sums, folds
// and the difference all sit in one combinational pass between the two registers.
// Reset clears both stage valid bits; the data registers are not reset.
// When the receiver stalls, the result register holds its item and the
// input register may still fill, so one more item is taken before
// prefixes.ready drops; ready returns in the cycle the result is taken.
module nptv6_prefix_adjustment (
  input logic         clk,
  input logic         rst,
  nptv6_in_if.sink    prefixes,
  nptv6_out_if.source result
);
  import nptv6_pkg::*;

  // input register
  logic    s1_valid;
  len_t    s1_len;
  prefix_t s1_inner;
  prefix_t s1_outer;

  // result register
  logic    out_valid;
  word_t   adjustment;

  logic    s1_move;
  word_t   inner_sum;
  word_t   outer_sum;
  word_t   adjustment_next;

  assign s1_move        = !out_valid || result.ready;
  assign prefixes.ready = !s1_valid || s1_move;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (prefixes.ready) begin
      s1_valid <= prefixes.valid;
    end
    if (prefixes.ready && prefixes.valid) begin
      s1_len   <= prefixes.prefix_length;
      s1_inner <= {prefixes.inner_prefix_hi, prefixes.inner_prefix_lo};
      s1_outer <= {prefixes.outer_prefix_hi, prefixes.outer_prefix_lo};
    end
  end

  nptv6_prefix_sum u_inner_sum (
    .prefix_length (s1_len),
    .prefix        (s1_inner),
    .sum           (inner_sum)
  );

  nptv6_prefix_sum u_outer_sum (
    .prefix_length (s1_len),
    .prefix        (s1_outer),
    .sum           (outer_sum)
  );

  // inner minus outer in ones' complement, complement taken on 16 bits
  assign adjustment_next = fold16({{(SumBits-WordBits){1'b0}}, inner_sum}
                                  + {{(SumBits-WordBits){1'b0}}, ~outer_sum});

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= s1_valid;
    end
    if (s1_move && s1_valid) begin
      adjustment <= adjustment_next;
    end
  end

  assign result.valid      = out_valid;
  assign result.adjustment = adjustment;

  // an accepted item reaches the input register
  assert property (@(posedge clk) disable iff (rst)
    prefixes.valid && prefixes.ready |=> s1_valid)
    else $error("accepted item missing from input register");

  // a loaded item reaches the result register
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_move |=> out_valid)
    else $error("item lost between stages");

  // zero length gives the all-ones adjustment
  assert property (@(posedge clk) disable iff (rst)
    s1_valid && s1_move && s1_len == '0 |=> result.adjustment == WORD_MASK)
    else $error("zero length adjustment is not all ones");

endmodule

// File: src/nptv6_prefix_sum.sv
`timescale 1ns / 1ps

module nptv6_prefix_sum (
  input  nptv6_pkg::len_t    prefix_length,
  input  nptv6_pkg::prefix_t prefix,
  output nptv6_pkg::word_t   sum
);
  import nptv6_pkg::*;

  len_t    len_sat;
  prefix_t mask;
  prefix_t masked;
  word_t   words [NumWords];
  sum_t    pair  [NumWords/2];
  sum_t    quad  [NumWords/4];
  sum_t    total;

  // lengths above 128 cover the whole prefix
  assign len_sat = (prefix_length > MAX_PREFIX_BITS) ? MAX_PREFIX_BITS : prefix_length;

  // keep the leading len_sat bits, partial word keeps its top bits
  assign mask   = ~({PrefixBits{1'b1}} >> len_sat);
  assign masked = prefix & mask;

  // split into words, word 0 is the most significant
  always_comb begin
    for (int i = 0; i < NumWords; i++) begin
      words[i] = masked[PrefixBits-1-WordBits*i -: WordBits];
    end
  end

  // three-level adder tree
  always_comb begin
    for (int i = 0; i < NumWords/2; i++) begin
      pair[i] = sum_t'(words[2*i]) + sum_t'(words[2*i+1]);
    end
    for (int i = 0; i < NumWords/4; i++) begin
      quad[i] = pair[2*i] + pair[2*i+1];
    end
    total = quad[0] + quad[1];
  end

  assign sum = fold16(total);

endmodule
